// ===== rtl/ray_plane_intersect_core_assert.svh =====
`ifndef RAY_PLANE_INTERSECT_CORE_ASSERT_SVH
`define RAY_PLANE_INTERSECT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RPI_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RPI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/rpi_pkg.sv =====
package rpi_pkg;

  // Quotient width of the divider, one bit per stage
  localparam int QuoW = 64;
  // Denominator magnitude width
  localparam int DenW = 64;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_PPT_X = 3'd0,
    REG_PPT_Y = 3'd1,
    REG_PPT_Z = 3'd2,
    REG_NRM_X = 3'd3,
    REG_NRM_Y = 3'd4,
    REG_NRM_Z = 3'd5,
    REG_EPS   = 3'd6
  } rpi_reg_e;

  typedef logic [31:0] rpi_word_t;

  // One ray: origin and direction, x/y/z in elements 0/1/2
  typedef struct packed {
    rpi_word_t [2:0] o;
    rpi_word_t [2:0] d;
  } rpi_ray_t;

  // Data riding along with the divider
  typedef struct packed {
    rpi_ray_t ray;
    logic     tsign;
    logic     par;
    logic     big;
  } rpi_side_t;

endpackage

// ===== rtl/ray_plane_intersect_core.sv =====
// Ray / plane intersection, signed fixed point, fully pipelined.
// Pipeline from input transaction to result: 5 front stages,
// 64 divider stages at one quotient bit each, 5 back stages.
// Throughput: one ray per cycle; the whole pipe stalls while a result waits.
// Reset: async active low; clears valid bits and loads plane (0,0,0),
// normal (0,1,0), epsilon 4295.
`include "ray_plane_intersect_core_assert.svh"

module ray_plane_intersect_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // ray input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  origin_x_i,
  input  logic signed [31:0]  origin_y_i,
  input  logic signed [31:0]  origin_z_i,
  input  logic signed [31:0]  dir_x_i,
  input  logic signed [31:0]  dir_y_i,
  input  logic signed [31:0]  dir_z_i,
  // hit output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  hit_x_o,
  output logic signed [31:0]  hit_y_o,
  output logic signed [31:0]  hit_z_o,
  output logic                parallel_o,
  output logic                overflow_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rpi_pkg::*;

  localparam int NumW = 66 + FRAC_BITS;   // shifted numerator magnitude
  localparam int HiW  = NumW - QuoW;      // part above the quotient window
  localparam int AccW = 98;               // o*2^F +/- t*d
  localparam int ShW  = AccW - FRAC_BITS;

  logic en;

  // ---------------- configuration registers ----------------
  logic [2:0][31:0] ppt_q;
  logic [2:0][31:0] nrm_q;
  logic [31:0]      eps_q;
  logic             wr;
  rpi_reg_e         widx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign widx   = rpi_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppt_q <= '0;
      nrm_q <= {32'd0, 32'(1) << FRAC_BITS, 32'd0};
      eps_q <= 32'd4295;
    end else if (wr) begin
      unique case (widx)
        REG_PPT_X: ppt_q[0] <= pwdata;
        REG_PPT_Y: ppt_q[1] <= pwdata;
        REG_PPT_Z: ppt_q[2] <= pwdata;
        REG_NRM_X: nrm_q[0] <= pwdata;
        REG_NRM_Y: nrm_q[1] <= pwdata;
        REG_NRM_Z: nrm_q[2] <= pwdata;
        REG_EPS:   eps_q    <= pwdata;
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_PPT_X: prdata = ppt_q[0];
      REG_PPT_Y: prdata = ppt_q[1];
      REG_PPT_Z: prdata = ppt_q[2];
      REG_NRM_X: prdata = nrm_q[0];
      REG_NRM_Y: prdata = nrm_q[1];
      REG_NRM_Z: prdata = nrm_q[2];
      REG_EPS:   prdata = eps_q;
      default:   prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- A1: capture ray, P - O ----------------
  logic             a1_v_q;
  rpi_ray_t         a1_ray_q;
  logic [2:0][32:0] a1_diff_q;
  rpi_ray_t         in_ray;

  assign in_ray.o = {origin_z_i, origin_y_i, origin_x_i};
  assign in_ray.d = {dir_z_i, dir_y_i, dir_x_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_ray_q <= in_ray;
      for (int i = 0; i < 3; i++) begin
        a1_diff_q[i] <= {ppt_q[i][31], ppt_q[i]} - {in_ray.o[i][31], in_ray.o[i]};
      end
    end
  end

  // ---------------- A2: products ----------------
  logic             a2_v_q;
  rpi_ray_t         a2_ray_q;
  logic [2:0][63:0] a2_pden_q;
  logic [2:0][64:0] a2_pnum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a2_ray_q <= a1_ray_q;
      for (int i = 0; i < 3; i++) begin
        a2_pden_q[i] <= $signed({{32{a1_ray_q.d[i][31]}}, a1_ray_q.d[i]})
                      * $signed({{32{nrm_q[i][31]}}, nrm_q[i]});
        a2_pnum_q[i] <= $signed({{32{a1_diff_q[i][32]}}, a1_diff_q[i]})
                      * $signed({{33{nrm_q[i][31]}}, nrm_q[i]});
      end
    end
  end

  // ---------------- A3: dot products ----------------
  logic        a3_v_q;
  rpi_ray_t    a3_ray_q;
  logic [65:0] a3_den_q;
  logic [66:0] a3_num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_ray_q <= a2_ray_q;
      a3_den_q <= {{2{a2_pden_q[0][63]}}, a2_pden_q[0]}
                + {{2{a2_pden_q[1][63]}}, a2_pden_q[1]}
                + {{2{a2_pden_q[2][63]}}, a2_pden_q[2]};
      a3_num_q <= {{2{a2_pnum_q[0][64]}}, a2_pnum_q[0]}
                + {{2{a2_pnum_q[1][64]}}, a2_pnum_q[1]}
                + {{2{a2_pnum_q[2][64]}}, a2_pnum_q[2]};
    end
  end

  // ---------------- A4: magnitudes ----------------
  logic            a4_v_q;
  rpi_ray_t        a4_ray_q;
  logic [DenW-1:0] a4_dmag_q;
  logic [65:0]     a4_nmag_q;
  logic            a4_tsign_q;
  logic [65:0]     den_abs;
  logic [66:0]     num_abs;

  assign den_abs = a3_den_q[65] ? (66'd0 - a3_den_q) : a3_den_q;
  assign num_abs = a3_num_q[66] ? (67'd0 - a3_num_q) : a3_num_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a4_ray_q   <= a3_ray_q;
      a4_dmag_q  <= den_abs[DenW-1:0];
      a4_nmag_q  <= num_abs[65:0];
      a4_tsign_q <= a3_den_q[65] ^ a3_num_q[66];
    end
  end

  // ---------------- A5: parallel test, quotient range, divider setup ----------------
  logic            a5_v_q;
  logic [DenW-1:0] a5_rem_q;
  logic [QuoW-1:0] a5_lo_q;
  logic [DenW-1:0] a5_den_q;
  rpi_side_t       a5_side_q;
  logic [NumW-1:0] nshift;
  logic [HiW-1:0]  nhi;

  assign nshift = {a4_nmag_q, {FRAC_BITS{1'b0}}};
  assign nhi    = nshift[NumW-1:QuoW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a5_rem_q           <= DenW'(nhi);
      a5_lo_q            <= nshift[QuoW-1:0];
      a5_den_q           <= a4_dmag_q;
      a5_side_q.ray      <= a4_ray_q;
      a5_side_q.tsign    <= a4_tsign_q;
      a5_side_q.par      <= (a4_dmag_q < {32'd0, eps_q}) || (a4_dmag_q == '0);
      // quotient does not fit 64 bits
      a5_side_q.big      <= DenW'(nhi) >= a4_dmag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      a3_v_q <= 1'b0;
      a4_v_q <= 1'b0;
      a5_v_q <= 1'b0;
    end else if (en) begin
      a1_v_q <= in_valid_i;
      a2_v_q <= a1_v_q;
      a3_v_q <= a2_v_q;
      a4_v_q <= a3_v_q;
      a5_v_q <= a4_v_q;
    end
  end

  // ---------------- divider ----------------
  logic            dv_v;
  logic [QuoW-1:0] dv_q;
  rpi_side_t       dv_side;

  rpi_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a5_v_q),
    .rem_i   (a5_rem_q),
    .num_i   (a5_lo_q),
    .den_i   (a5_den_q),
    .side_i  (a5_side_q),
    .valid_o (dv_v),
    .quo_o   (dv_q),
    .side_o  (dv_side)
  );

  // ---------------- B1: saturate t, direction magnitudes ----------------
  logic             b1_v_q;
  logic [QuoW-1:0]  b1_tmag_q;
  logic             b1_tneg_q;
  logic             b1_tovf_q;
  logic [2:0][31:0] b1_dmag_q;
  logic [2:0]       b1_dneg_q;
  logic [2:0][31:0] b1_o_q;
  logic             b1_par_q;
  logic             tneg;
  logic [QuoW-1:0]  tmag;
  logic             tovf;

  localparam logic [QuoW-1:0] TPosMax = {1'b0, {(QuoW-1){1'b1}}};
  localparam logic [QuoW-1:0] TNegMax = {1'b1, {(QuoW-1){1'b0}}};

  always_comb begin
    tneg = dv_side.tsign && (dv_side.big || (dv_q != '0));
    tmag = dv_q;
    tovf = 1'b0;
    if (dv_side.big) begin
      tovf = 1'b1;
      tmag = tneg ? TNegMax : TPosMax;
    end else if (!tneg && dv_q[QuoW-1]) begin
      tovf = 1'b1;
      tmag = TPosMax;
    end else if (tneg && dv_q[QuoW-1] && (dv_q[QuoW-2:0] != '0)) begin
      tovf = 1'b1;
      tmag = TNegMax;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_tmag_q <= tmag;
      b1_tneg_q <= tneg;
      b1_tovf_q <= tovf;
      b1_par_q  <= dv_side.par;
      b1_o_q    <= dv_side.ray.o;
      for (int i = 0; i < 3; i++) begin
        b1_dneg_q[i] <= dv_side.ray.d[i][31];
        b1_dmag_q[i] <= dv_side.ray.d[i][31] ? (32'd0 - dv_side.ray.d[i])
                                             : dv_side.ray.d[i];
      end
    end
  end

  // ---------------- B2: partial products of t*|d| ----------------
  logic             b2_v_q;
  logic [2:0][63:0] b2_pplo_q;
  logic [2:0][63:0] b2_pphi_q;
  logic [2:0]       b2_sgn_q;
  logic             b2_tovf_q;
  logic [2:0][31:0] b2_o_q;
  logic             b2_par_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_tovf_q <= b1_tovf_q;
      b2_par_q  <= b1_par_q;
      b2_o_q    <= b1_o_q;
      for (int i = 0; i < 3; i++) begin
        b2_pplo_q[i] <= {32'd0, b1_tmag_q[31:0]} * {32'd0, b1_dmag_q[i]};
        b2_pphi_q[i] <= {32'd0, b1_tmag_q[63:32]} * {32'd0, b1_dmag_q[i]};
        b2_sgn_q[i]  <= b1_tneg_q ^ b1_dneg_q[i];
      end
    end
  end

  // ---------------- B3: combine partial products ----------------
  logic             b3_v_q;
  logic [2:0][95:0] b3_prod_q;
  logic [2:0]       b3_sgn_q;
  logic             b3_tovf_q;
  logic [2:0][31:0] b3_o_q;
  logic             b3_par_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_sgn_q  <= b2_sgn_q;
      b3_tovf_q <= b2_tovf_q;
      b3_par_q  <= b2_par_q;
      b3_o_q    <= b2_o_q;
      for (int i = 0; i < 3; i++) begin
        b3_prod_q[i] <= {32'd0, b2_pplo_q[i]} + {b2_pphi_q[i], 32'd0};
      end
    end
  end

  // ---------------- B4: o*2^F +/- t*d ----------------
  logic                  b4_v_q;
  logic [2:0][AccW-1:0]  b4_acc_q;
  logic                  b4_tovf_q;
  logic                  b4_par_q;
  logic [2:0][AccW-1:0]  ofix;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ofix[i] = {{(AccW-32){b3_o_q[i][31]}}, b3_o_q[i]} << FRAC_BITS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_tovf_q <= b3_tovf_q;
      b4_par_q  <= b3_par_q;
      for (int i = 0; i < 3; i++) begin
        b4_acc_q[i] <= b3_sgn_q[i] ? (ofix[i] - {2'b00, b3_prod_q[i]})
                                   : (ofix[i] + {2'b00, b3_prod_q[i]});
      end
    end
  end

  // ---------------- B5: scale back, saturate, output register ----------------
  logic [2:0][31:0]  hit_d;
  logic [2:0]        sat;
  logic [2:0][31:0]  hit_q;
  logic              par_q;
  logic              ovf_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [ShW-1:0] sh;
      logic [ShW-32:0] top;
      sh  = b4_acc_q[i][AccW-1:FRAC_BITS];
      top = sh[ShW-1:31];
      sat[i] = !((&top) || (~|top));
      if (!sat[i]) begin
        hit_d[i] = sh[31:0];
      end else if (sh[ShW-1]) begin
        hit_d[i] = 32'h8000_0000;
      end else begin
        hit_d[i] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      par_q <= b4_par_q;
      if (b4_par_q) begin
        hit_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        hit_q <= hit_d;
        ovf_q <= b4_tovf_q || (|sat);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      b1_v_q  <= dv_v;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      out_v_q <= b4_v_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign hit_x_o     = hit_q[0];
  assign hit_y_o     = hit_q[1];
  assign hit_z_o     = hit_q[2];
  assign parallel_o  = par_q;
  assign overflow_o  = ovf_q;

  // ---------------- assertions ----------------
  // parallel result carries zero point and no overflow
  logic par_clean;
  assign par_clean = (hit_q == '0) && !ovf_q;

  `RPI_ASSERT_NOW(a_par_zero, out_valid_o && parallel_o, par_clean, "parallel result not zero")
  `RPI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "waiting result dropped")
  `RPI_ASSERT_NOW(a_stall_in, out_valid_o && !out_ready_i, !in_ready_o, "ray taken during stall")
  `RPI_ASSERT_NEXT(a_take, in_valid_i && in_ready_o, a1_v_q, "accepted ray lost")

endmodule

// ===== rtl/rpi_divider.sv =====
module rpi_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [rpi_pkg::DenW-1:0]      rem_i,
  input  logic [rpi_pkg::QuoW-1:0]      num_i,
  input  logic [rpi_pkg::DenW-1:0]      den_i,
  input  rpi_pkg::rpi_side_t            side_i,
  output logic                          valid_o,
  output logic [rpi_pkg::QuoW-1:0]      quo_o,
  output rpi_pkg::rpi_side_t            side_o
);
  import rpi_pkg::*;

  // Restoring divider, one quotient bit per stage
  logic                v_q   [QuoW];
  logic [QuoW-1:0]     a_q   [QuoW];
  logic [DenW-1:0]     dn_q  [QuoW];
  rpi_side_t           s_q   [QuoW];
  logic [DenW-1:0]     r_q   [QuoW-1];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic            v_in;
    logic [DenW-1:0] r_in;
    logic [QuoW-1:0] a_in;
    logic [DenW-1:0] dn_in;
    rpi_side_t       s_in;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = rem_i;
      assign a_in  = num_i;
      assign dn_in = den_i;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = v_q[k-1];
      assign r_in  = r_q[k-1];
      assign a_in  = a_q[k-1];
      assign dn_in = dn_q[k-1];
      assign s_in  = s_q[k-1];
    end

    // shift in next dividend bit, trial subtract
    assign trial = {r_in, a_in[QuoW-1]};
    assign diff  = trial - {1'b0, dn_in};
    assign ge    = !diff[DenW];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]  <= {a_in[QuoW-2:0], ge};
        dn_q[k] <= dn_in;
        s_q[k]  <= s_in;
      end
    end

    if (k < QuoW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          r_q[k] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
        end
      end
    end
  end

  assign valid_o = v_q[QuoW-1];
  assign quo_o   = a_q[QuoW-1];
  assign side_o  = s_q[QuoW-1];

endmodule

// ===== tb/tb_ray_plane_intersect_core.sv =====
`timescale 1ns / 100ps

module tb_ray_plane_intersect_core;
  import rpi_pkg::*;

  localparam int FracBits   = 16;
  localparam int PipeDepth  = 74;
  localparam int CycleLimit = 600000;
  localparam int PhaseRays  = 130;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        par;
    logic        ovf;
  } hit_t;

  typedef struct packed {
    rpi_ray_t ray;
    logic     typed;
    hit_t     hit;
  } ray_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] origin_x_i, origin_y_i, origin_z_i;
  logic [31:0] dir_x_i, dir_y_i, dir_z_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] hit_x_o, hit_y_o, hit_z_o;
  logic        parallel_o, overflow_o;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  // Shadow copy of the plane registers
  logic [31:0] plane_pt  [3];
  logic [31:0] plane_nrm [3];
  logic [31:0] par_eps;

  hit_t     hit_pending[$];
  ray_row_t ray_table[$];
  bit       failed;
  int       hits_seen;

  ray_plane_intersect_core #(.FRAC_BITS(FracBits)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .origin_x_i(origin_x_i), .origin_y_i(origin_y_i), .origin_z_i(origin_z_i),
    .dir_x_i(dir_x_i), .dir_y_i(dir_y_i), .dir_z_i(dir_z_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .hit_x_o(hit_x_o), .hit_y_o(hit_y_o), .hit_z_o(hit_z_o),
    .parallel_o(parallel_o), .overflow_o(overflow_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Intersection point for one ray under the current plane settings
  function automatic hit_t intersect_ray(rpi_ray_t r);
    logic signed [127:0] den, num, a, b, acc, prod;
    logic signed [127:0] lim_lo, lim_hi;
    logic [127:0] den_mag, num_mag, quo, dmag;
    logic tneg;
    logic [31:0] c [3];
    hit_t h;
    den = '0;
    num = '0;
    h = '0;
    lim_lo = -128'sd2147483648;
    lim_hi = 128'sd2147483647;
    for (int i = 0; i < 3; i++) begin
      a = $signed(r.d[i]);
      b = $signed(plane_nrm[i]);
      den = den + a * b;
      a = $signed(plane_pt[i]);
      acc = $signed(r.o[i]);
      a = a - acc;
      num = num + a * b;
    end
    den_mag = den[127] ? -den : den;
    if (den_mag < par_eps || den_mag == 0) begin
      h.par = 1'b1;
      return h;
    end
    num_mag = num[127] ? -num : num;
    quo = (num_mag << FracBits) / den_mag;
    tneg = (num[127] != den[127]) && (quo != 0);
    if (!tneg && quo > 128'h7fff_ffff_ffff_ffff) begin
      quo = 128'h7fff_ffff_ffff_ffff;
      h.ovf = 1'b1;
    end
    if (tneg && quo > 128'h8000_0000_0000_0000) begin
      quo = 128'h8000_0000_0000_0000;
      h.ovf = 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      a = $signed(r.d[i]);
      dmag = a[127] ? -a : a;
      prod = quo[63:0] * dmag;
      if (tneg != a[127]) prod = -prod;
      acc = $signed(r.o[i]);
      acc = (acc <<< FracBits) + prod;
      acc = acc >>> FracBits;
      if (acc < lim_lo) begin
        acc = lim_lo;
        h.ovf = 1'b1;
      end
      if (acc > lim_hi) begin
        acc = lim_hi;
        h.ovf = 1'b1;
      end
      c[i] = acc[31:0];
    end
    h.x = c[0];
    h.y = c[1];
    h.z = c[2];
    return h;
  endfunction

  // Register write, setup then access cycle
  task automatic plane_write(rpi_reg_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx) << 2;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PPT_X: plane_pt[0]  = val;
      REG_PPT_Y: plane_pt[1]  = val;
      REG_PPT_Z: plane_pt[2]  = val;
      REG_NRM_X: plane_nrm[0] = val;
      REG_NRM_Y: plane_nrm[1] = val;
      REG_NRM_Z: plane_nrm[2] = val;
      REG_EPS:   par_eps      = val;
      default: ;
    endcase
  endtask

  task automatic load_plane(logic [31:0] px, py, pz, nx, ny, nz, eps);
    plane_write(REG_PPT_X, px);
    plane_write(REG_PPT_Y, py);
    plane_write(REG_PPT_Z, pz);
    plane_write(REG_NRM_X, nx);
    plane_write(REG_NRM_Y, ny);
    plane_write(REG_NRM_Z, nz);
    plane_write(REG_EPS, eps);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Coordinate mix: full range, tiny, small integers, extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  // Drive one ray; called right after a rising edge, returns the same way
  task automatic send_ray(rpi_ray_t r, logic typed, hit_t h);
    int g;
    in_valid_i <= 1'b1;
    origin_x_i <= r.o[0];
    origin_y_i <= r.o[1];
    origin_z_i <= r.o[2];
    dir_x_i    <= r.d[0];
    dir_y_i    <= r.d[1];
    dir_z_i    <= r.d[2];
    do @(posedge clk_i); while (!in_ready_o);
    hit_pending.push_back(typed ? h : intersect_ray(r));
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int n);
    rpi_ray_t r;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < 3; i++) begin
        r.o[i] = rand_coord();
        r.d[i] = rand_coord();
      end
      send_ray(r, 1'b0, '0);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (hit_pending.size() > 0) @(posedge clk_i);
    repeat (PipeDepth + 6) @(posedge clk_i);
  endtask

  task automatic add_row(logic [31:0] ox, oy, oz, dx, dy, dz, logic typed, hit_t h);
    ray_row_t row;
    row.ray.o[0] = ox; row.ray.o[1] = oy; row.ray.o[2] = oz;
    row.ray.d[0] = dx; row.ray.d[1] = dy; row.ray.d[2] = dz;
    row.typed = typed;
    row.hit   = h;
    ray_table.push_back(row);
  endtask

  // Stimulus
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    origin_x_i  = '0; origin_y_i = '0; origin_z_i = '0;
    dir_x_i     = '0; dir_y_i    = '0; dir_z_i    = '0;
    psel        = 1'b0; penable  = 1'b0; pwrite   = 1'b0;
    paddr       = '0;   pwdata   = '0;
    failed      = 1'b0;
    plane_pt    = '{32'd0, 32'd0, 32'd0};
    plane_nrm   = '{32'd0, 32'd65536, 32'd0};
    par_eps     = 32'd4295;

    // Reset plane y=0, normal +y: typed rows first
    add_row(0, 32'h1_0000, 0, 0, 32'hffff_0000, 0, 1, '{0, 0, 0, 0, 0});
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h1_0000, 0, 0, 1,
            '{0, 0, 0, 1, 0});
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 1,
            '{0, 0, 0, 1, 0});
    add_row(0, 32'h1_0000, 0, 32'h7fff_ffff, 1, 0, 1,
            '{32'h8000_0000, 0, 0, 0, 1});
    add_row(0, 32'h1_0000, 0, 32'h8000_0000, 1, 0, 1,
            '{32'h7fff_ffff, 0, 0, 0, 1});
    // Extremes and sign mixes through the predictor
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1, 0, '0);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 32'h8000_0000, 1, 0, '0);
    add_row(32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff,
            32'h7fff_ffff, 0, '0);
    add_row(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 0, '0);
    add_row(0, 32'hffff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, '0);
    add_row(32'h1234_5678, 32'h0003_8000, 32'hdead_beef, 32'h0001_0000, 32'hffff_8000,
            32'h0002_0000, 0, '0);
    add_row(0, 32'h7fff_ffff, 0, 0, 32'hffff_ffff, 0, 0, '0);
    add_row(0, 32'h8000_0000, 0, 0, 1, 0, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ray_table[i]) send_ray(ray_table[i].ray, ray_table[i].typed, ray_table[i].hit);
    send_random(PhaseRays);
    drain();

    // Near-parallel normal with a zero-width epsilon: tiny denominators, t saturation
    load_plane(32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_fffe, 0, 0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 0, 1, 32'hffff_ffff, 0, 0, '0);
    send_ray(ray_table[$].ray, 1'b0, '0);
    add_row(32'h7fff_ffff, 32'h7fff_ffff, 0, 32'hffff_ffff, 1, 0, 0, '0);
    send_ray(ray_table[$].ray, 1'b0, '0);
    send_random(PhaseRays);
    drain();

    // Extremes of every register
    load_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_random(PhaseRays);
    drain();
    load_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
    send_random(PhaseRays);
    drain();

    // Fractional normal: epsilon boundary is reachable
    load_plane(0, 0, 32'h1_0000, 1, 0, 2, 3);
    add_row(0, 0, 0, 1, 0, 1, 0, '0);
    send_ray(ray_table[$].ray, 1'b0, '0);
    add_row(0, 0, 0, 1, 0, 0, 0, '0);
    send_ray(ray_table[$].ray, 1'b0, '0);
    send_random(PhaseRays);
    drain();

    // Random planes
    for (int p = 0; p < 4; p++) begin
      load_plane(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), $urandom_range(0, 1) ? $urandom : $urandom_range(0, 70000));
      send_random(PhaseRays);
      drain();
    end

    if (!failed) begin
      $display("tb_ray_plane_intersect_core: PASS");
    end else begin
      $display("tb_ray_plane_intersect_core: FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off once 40 results have been taken
  initial begin
    int stall;
    int mode_left;
    bit busy_mode;
    bit held;
    hit_t exp_hit;
    out_ready_i = 1'b0;
    hits_seen   = 0;
    stall       = 0;
    mode_left   = 0;
    busy_mode   = 1'b0;
    held        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (hit_pending.size() == 0) begin
          $error("unexpected result transaction");
          failed = 1'b1;
        end else begin
          exp_hit = hit_pending.pop_front();
          hits_seen++;
          if (hit_x_o !== exp_hit.x) begin
            $error("hit_x exp %h got %h", exp_hit.x, hit_x_o);
            failed = 1'b1;
          end
          if (hit_y_o !== exp_hit.y) begin
            $error("hit_y exp %h got %h", exp_hit.y, hit_y_o);
            failed = 1'b1;
          end
          if (hit_z_o !== exp_hit.z) begin
            $error("hit_z exp %h got %h", exp_hit.z, hit_z_o);
            failed = 1'b1;
          end
          if (parallel_o !== exp_hit.par) begin
            $error("parallel exp %b got %b", exp_hit.par, parallel_o);
            failed = 1'b1;
          end
          if (overflow_o !== exp_hit.ovf) begin
            $error("overflow exp %b got %b", exp_hit.ovf, overflow_o);
            failed = 1'b1;
          end
        end
      end
      if (mode_left == 0) begin
        busy_mode = $urandom_range(0, 2) != 0;
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (!held && hits_seen >= 40) begin
        held  = 1'b1;
        stall = 300;
      end else if (stall == 0 && busy_mode) begin
        stall = gap_len();
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_ray_plane_intersect_core: FAIL");
    $finish;
  end

endmodule
